@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dmr_pkg.sv @@
// Package with constants and controller/datapath interface types of the MAC rewriter.
`timescale 1ns / 1ps

package dmr_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    // Header geometry: lengths and byte offsets within the frame.
    localparam logic [5:0] HDR_LEN      = 6'd34;
    localparam logic [5:0] MAC_LEN      = 6'd6;
    localparam logic [5:0] ETYPE_HI_OFS = 6'd12;
    localparam logic [5:0] ETYPE_LO_OFS = 6'd13;
    localparam logic [5:0] PROTO_OFS    = 6'd23;
    localparam logic [5:0] DIP_OFS      = 6'd30;

    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] PROTO_TCP     = 8'h06;
    localparam logic [7:0] PROTO_UDP     = 8'h11;

    // Input command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    // Width used to range-check an entry index against the table depth.
    localparam int ENTRY_XW = 9;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_tbl_entry;

    typedef struct packed {
        logic take_hdr;
        logic take_pass;
        logic tbl_wr;
        logic scan_start;
        logic scan_run;
        logic drain_start;
        logic drain_run;
        logic drain_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic hdr_phase;
        logic hdr_final;
        logic qualify;
        logic scan_done;
        logic drain_done;
    } t_dp_status;

endpackage

@@ design/ipv4_dest_mac_rewriter_top.sv @@
// Top level of the IPv4 destination MAC rewriter.
`timescale 1ns / 1ps
// Usage: the input channel (i_in_valid / o_in_stall) carries one transfer per item.
// With i_cmd at frame value the transfer is one frame byte in wire order, i_frame_last
// marking the final byte; with i_cmd at entry value it writes lookup slot i_entry_index
// and produces nothing. The output channel (o_out_valid / i_out_stall) carries frame
// bytes after any MAC rewrite, with o_out_last and o_mac_rewritten.
// The first 34 bytes of a frame are held. On the 34th byte the block checks for IPv4
// carrying TCP or UDP, scans the table one slot per cycle (skipped for other frames),
// and emits the 34 held bytes, one per cycle while the output is not stalled, with
// the destination MAC replaced by the last enabled matching slot. The input is
// stalled for that whole burst. Bytes after the header pass through the output
// register at one byte per cycle while the receiver does not stall. A frame shorter
// than 34 bytes is replayed unchanged when its last byte arrives. A stalled receiver
// holds the output register and, through it, the input. Reset empties the output,
// disables all table slots and starts a new frame. No clearing pass is needed after
// reset.

module ipv4_dest_mac_rewriter_top #(
    parameter int TABLE_ENTRIES = dmr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_ip,
    input  logic [47:0] i_entry_mac,
    input  logic        i_entry_valid,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_mac_rewritten
);
    import dmr_pkg::*;

    t_dp_cmd    w_ctl;
    t_dp_status w_sts;

    // The controller sequences accept, table scan and header replay.
    dmr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_frame_last (i_frame_last),
        .i_sts        (w_sts),
        .o_ctl        (w_ctl)
    );

    // The datapath owns the header store, the table memory and the output register.
    dmr_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_frame_byte    (i_frame_byte),
        .i_frame_last    (i_frame_last),
        .i_entry_index   (i_entry_index),
        .i_entry_ip      (i_entry_ip),
        .i_entry_mac     (i_entry_mac),
        .i_entry_valid   (i_entry_valid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_mac_rewritten (o_mac_rewritten)
    );

endmodule

@@ design/dmr_ctrl.sv @@
// Controller state machine of the MAC rewriter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic                i_frame_last,
    input  dmr_pkg::t_dp_status i_sts,
    output dmr_pkg::t_dp_cmd    o_ctl
);
    import dmr_pkg::*;

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;
    logic [2:0] w_takes;

    assign o_in_stall = !((r_state == S_RUN) && i_sts.out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_takes    = {o_ctl.take_hdr, o_ctl.take_pass, o_ctl.tbl_wr};

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    if (i_cmd == CMD_ENTRY) begin
                        o_ctl.tbl_wr = 1'b1;
                    end else if (i_sts.hdr_phase) begin
                        o_ctl.take_hdr = 1'b1;
                        if (i_sts.hdr_final) begin
                            o_ctl.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else if (i_frame_last) begin
                            o_ctl.drain_start = 1'b1;
                            n_state           = S_DRAIN;
                        end
                    end else begin
                        o_ctl.take_pass = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (!i_sts.qualify || i_sts.scan_done) begin
                    o_ctl.drain_start = 1'b1;
                    n_state           = S_DRAIN;
                end else begin
                    o_ctl.scan_run = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.drain_done) begin
                    o_ctl.drain_end = 1'b1;
                    n_state         = S_RUN;
                end else begin
                    o_ctl.drain_run = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_IMPLIES(a_busy_stalls, r_state != S_RUN, o_in_stall, "input taken while busy")
    `ASSERT_NEXT(a_scan_follows, o_ctl.scan_start, r_state == S_SCAN, "scan did not start")
    `ASSERT_ALWAYS(a_one_take, $onehot0(w_takes), "two transfer actions at once")

endmodule

@@ design/dmr_dp.sv @@
// Datapath of the MAC rewriter: header store, lookup table, scan and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmr_dp #(
    parameter int TABLE_ENTRIES = dmr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmr_pkg::t_dp_cmd    i_ctl,
    output dmr_pkg::t_dp_status o_sts,
    input  logic [7:0]          i_frame_byte,
    input  logic                i_frame_last,
    input  logic [3:0]          i_entry_index,
    input  logic [31:0]         i_entry_ip,
    input  logic [47:0]         i_entry_mac,
    input  logic                i_entry_valid,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last,
    output logic                o_mac_rewritten
);
    import dmr_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = $clog2(TABLE_ENTRIES + 1);

    // Header store and captured header fields.
    logic [7:0]  r_hdr_mem [0:HDR_LEN-1];
    logic [5:0]  r_pos;
    logic        r_burst_last;
    logic [7:0]  r_etype_hi;
    logic [7:0]  r_etype_lo;
    logic [7:0]  r_proto;
    logic [31:0] r_dip;

    // Lookup table.
    t_tbl_entry         r_tbl_mem [0:TABLE_ENTRIES-1];
    logic [TABLE_ENTRIES-1:0] r_tbl_en;
    logic [SW-1:0]      r_scan_idx;
    t_tbl_entry         r_tbl_rd;
    logic               r_tbl_rd_en;
    logic               r_tbl_rd_v;
    logic               r_hit;
    logic [47:0]        r_mac;

    // Header emission.
    logic [5:0]  r_emit_idx;
    logic [7:0]  r_hdr_rd;
    logic [5:0]  r_hdr_rd_ix;
    logic        r_hdr_rd_v;

    logic        r_out_v;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_rw;

    logic [ENTRY_XW-1:0] w_wr_ix;
    logic        w_wr_ok;
    logic        w_scan_more;
    logic        w_match;
    logic        w_out_free;
    logic        w_load;
    logic        w_issue;
    logic        w_frame_end;
    logic [47:0] w_mac_sh;
    logic [7:0]  w_drain_byte;

    assign w_wr_ix     = ENTRY_XW'(i_entry_index);
    assign w_wr_ok     = i_ctl.tbl_wr && (w_wr_ix < ENTRY_XW'(TABLE_ENTRIES));
    assign w_scan_more = r_scan_idx != SW'(TABLE_ENTRIES);
    assign w_match     = r_tbl_rd_v && r_tbl_rd_en && (r_tbl_rd.ip == r_dip);
    assign w_out_free  = !r_out_v || !i_out_stall;
    assign w_load      = i_ctl.drain_run && r_hdr_rd_v && w_out_free;
    assign w_issue     = i_ctl.drain_run && (r_emit_idx != r_pos) && (!r_hdr_rd_v || w_load);
    assign w_frame_end = (i_ctl.take_pass && i_frame_last) || (i_ctl.drain_end && r_burst_last);

    // The replacement MAC goes out first byte first from its top bits.
    assign w_mac_sh     = r_mac >> {3'(MAC_LEN - 6'd1) - r_hdr_rd_ix[2:0], 3'b000};
    assign w_drain_byte = (r_hit && (r_hdr_rd_ix < MAC_LEN)) ? w_mac_sh[7:0] : r_hdr_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_hdr) begin
            r_hdr_mem[r_pos] <= i_frame_byte;
            r_burst_last     <= i_frame_last;
            if (r_pos == ETYPE_HI_OFS) begin
                r_etype_hi <= i_frame_byte;
            end
            if (r_pos == ETYPE_LO_OFS) begin
                r_etype_lo <= i_frame_byte;
            end
            if (r_pos == PROTO_OFS) begin
                r_proto <= i_frame_byte;
            end
            if (r_pos >= DIP_OFS) begin
                r_dip <= {r_dip[23:0], i_frame_byte};
            end
        end
        if (w_issue) begin
            r_hdr_rd    <= r_hdr_mem[r_emit_idx];
            r_hdr_rd_ix <= r_emit_idx;
        end
        if (w_wr_ok) begin
            r_tbl_mem[w_wr_ix[IW-1:0]] <= '{ip: i_entry_ip, mac: i_entry_mac};
        end
        if (i_ctl.scan_run && w_scan_more) begin
            r_tbl_rd    <= r_tbl_mem[r_scan_idx[IW-1:0]];
            r_tbl_rd_en <= r_tbl_en[r_scan_idx[IW-1:0]];
        end
        if (w_match) begin
            r_mac <= r_tbl_rd.mac;
        end
        if (i_ctl.take_pass) begin
            r_out_byte <= i_frame_byte;
            r_out_last <= i_frame_last;
            r_out_rw   <= r_hit;
        end else if (w_load) begin
            r_out_byte <= w_drain_byte;
            r_out_last <= r_burst_last && (r_hdr_rd_ix == r_pos - 6'd1);
            r_out_rw   <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_tbl_en   <= '0;
            r_scan_idx <= '0;
            r_tbl_rd_v <= 1'b0;
            r_hit      <= 1'b0;
            r_emit_idx <= '0;
            r_hdr_rd_v <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_ctl.take_hdr) begin
                r_pos <= r_pos + 6'd1;
            end else if (w_frame_end) begin
                r_pos <= '0;
            end

            if (w_wr_ok) begin
                r_tbl_en[w_wr_ix[IW-1:0]] <= i_entry_valid;
            end

            if (i_ctl.scan_start) begin
                r_scan_idx <= '0;
                r_tbl_rd_v <= 1'b0;
            end else if (i_ctl.scan_run && w_scan_more) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_tbl_rd_v <= 1'b1;
            end else begin
                r_tbl_rd_v <= 1'b0;
            end

            // Later slots overwrite earlier hits, so the highest match wins.
            if (i_ctl.scan_start || w_frame_end) begin
                r_hit <= 1'b0;
            end else if (w_match) begin
                r_hit <= 1'b1;
            end

            if (i_ctl.drain_start) begin
                r_emit_idx <= '0;
                r_hdr_rd_v <= 1'b0;
            end else if (w_issue) begin
                r_emit_idx <= r_emit_idx + 6'd1;
                r_hdr_rd_v <= 1'b1;
            end else if (w_load) begin
                r_hdr_rd_v <= 1'b0;
            end

            if (i_ctl.take_pass || w_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.out_free   = w_out_free;
        o_sts.hdr_phase  = r_pos < HDR_LEN;
        o_sts.hdr_final  = r_pos == (HDR_LEN - 6'd1);
        o_sts.qualify    = (r_etype_hi == ETYPE_IPV4_HI) && (r_etype_lo == ETYPE_IPV4_LO) &&
                           ((r_proto == PROTO_TCP) || (r_proto == PROTO_UDP));
        o_sts.scan_done  = !w_scan_more && !r_tbl_rd_v;
        o_sts.drain_done = (r_emit_idx == r_pos) && !r_hdr_rd_v;
    end

    assign o_out_valid     = r_out_v;
    assign o_out_byte      = r_out_byte;
    assign o_out_last      = r_out_last;
    assign o_mac_rewritten = r_out_rw;

    `ASSERT_ALWAYS(a_pos_range, r_pos <= HDR_LEN, "header position beyond header length")
    `ASSERT_IMPLIES(a_rd_in_range, r_hdr_rd_v, r_hdr_rd_ix < r_pos, "header read past held bytes")

endmodule

@@ dv/ipv4_dest_mac_rewriter_top_tb.sv @@
// Self-checking testbench for the IPv4 destination MAC rewriter: directed, then random.
`timescale 1ns / 1ps

module ipv4_dest_mac_rewriter_top_tb;

    import dmr_pkg::*;

    // Header geometry as plain integers, so the prediction can loop and index freely.
    localparam int HDR_BYTES   = int'(HDR_LEN);
    localparam int MAC_BYTES   = int'(MAC_LEN);
    localparam int DIP_BASE    = int'(DIP_OFS);
    localparam int PROTO_BYTE  = int'(PROTO_OFS);
    localparam int ETYPE_HI_AT = int'(ETYPE_HI_OFS);
    localparam int ETYPE_LO_AT = int'(ETYPE_LO_OFS);
    localparam int SLOTS       = TABLE_ENTRIES_DEF;

    localparam int NO_INSERT   = 127;     // no entry command woven into a frame
    localparam int HOLD_CYCLES = 400;     // length of the long receiver hold-off
    localparam int ITEMS_PHASE = 10;      // minimum random transfers per idling phase

    localparam logic [15:0] ETYPE_IPV4 = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};

    // One input transfer, both commands folded into one record.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  idx;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        ena;
    } t_in_item;

    // One output transfer as the receiver sees it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rw;
    } t_out_beat;

    typedef enum logic [1:0] {ROW_BYTE, ROW_ENTRY, ROW_FRAME} t_row_kind;

    // A row of the directed table. Byte and entry rows carry the item itself; frame rows
    // describe a header and optionally weave an entry command in before byte ins_at.
    typedef struct packed {
        t_row_kind   kind;
        t_in_item    item;
        logic [6:0]  len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] dip;
        logic [6:0]  ins_at;
        logic        has_typed;
        t_out_beat   typed;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_cmd = CMD_FRAME;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_frame_last = 1'b0;
    logic [3:0]  i_entry_index = 4'h0;
    logic [31:0] i_entry_ip = 32'h0;
    logic [47:0] i_entry_mac = 48'h0;
    logic        i_entry_valid = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        o_mac_rewritten;

    ipv4_dest_mac_rewriter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_frame_byte    (i_frame_byte),
        .i_frame_last    (i_frame_last),
        .i_entry_index   (i_entry_index),
        .i_entry_ip      (i_entry_ip),
        .i_entry_mac     (i_entry_mac),
        .i_entry_valid   (i_entry_valid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_mac_rewritten (o_mac_rewritten)
    );

    // Predictor state: the header being collected, the lookup table and the decision
    // taken for the frame in progress. The table starts cleared, as after reset.
    logic [7:0]  hdr_bytes [HDR_BYTES];
    int          hdr_count = 0;
    logic [31:0] slot_ip   [SLOTS] = '{default: '0};
    logic [47:0] slot_mac  [SLOTS] = '{default: '0};
    logic        slot_on   [SLOTS] = '{default: 1'b0};
    logic        frame_hit = 1'b0;

    // Output bytes still owed by the block, oldest first.
    t_out_beat   pending_beats [$];
    t_out_beat   head_beat;

    t_stim_row   directed_rows [$];

    int  snd_idle_pct = 23;
    int  rcv_idle_pct = 70;
    logic rx_hold = 1'b0;
    event hold_kick;

    int  mismatch_count = 0;
    int  items_taken = 0;
    int  slot_writes = 0;
    int  bytes_out = 0;
    int  frames_out = 0;
    int  frames_rewritten = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_out_beat make_beat(input logic [7:0] d, input logic l, input logic r);
        t_out_beat b;
        b.data = d;
        b.last = l;
        b.rw   = r;
        return b;
    endfunction

    // Works out the bytes that one accepted transfer releases, updating the predictor's
    // own copy of the header, the table and the per-frame rewrite decision.
    task automatic forecast_frame_bytes(input t_in_item it, ref t_out_beat beats[$]);
        logic [31:0] dip;
        logic [47:0] new_mac;
        beats.delete();
        if (it.cmd == CMD_ENTRY) begin
            slot_ip[it.idx]  = it.ip;
            slot_mac[it.idx] = it.mac;
            slot_on[it.idx]  = it.ena;
            return;
        end
        if (hdr_count < HDR_BYTES) begin
            hdr_bytes[hdr_count] = it.data;
            hdr_count++;
            if (hdr_count == HDR_BYTES) begin
                // Header complete: only IPv4 carrying TCP or UDP is looked up, and the
                // highest enabled slot that matches the destination address wins.
                frame_hit = 1'b0;
                new_mac   = '0;
                if (hdr_bytes[ETYPE_HI_AT] == ETYPE_IPV4_HI &&
                    hdr_bytes[ETYPE_LO_AT] == ETYPE_IPV4_LO &&
                    (hdr_bytes[PROTO_BYTE] == PROTO_TCP ||
                     hdr_bytes[PROTO_BYTE] == PROTO_UDP)) begin
                    dip = {hdr_bytes[DIP_BASE], hdr_bytes[DIP_BASE + 1],
                           hdr_bytes[DIP_BASE + 2], hdr_bytes[DIP_BASE + 3]};
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_on[s] && slot_ip[s] == dip) begin
                            frame_hit = 1'b1;
                            new_mac   = slot_mac[s];
                        end
                    end
                    if (frame_hit) begin
                        for (int k = 0; k < MAC_BYTES; k++) begin
                            hdr_bytes[k] = new_mac[47 - 8 * k -: 8];
                        end
                    end
                end
                for (int k = 0; k < HDR_BYTES; k++) begin
                    beats.push_back(make_beat(hdr_bytes[k], it.last && k == HDR_BYTES - 1,
                                              frame_hit));
                end
            end else if (it.last) begin
                // A frame that ends inside its header is replayed untouched.
                for (int k = 0; k < hdr_count; k++) begin
                    beats.push_back(make_beat(hdr_bytes[k], k == hdr_count - 1, 1'b0));
                end
            end
        end else begin
            beats.push_back(make_beat(it.data, it.last, frame_hit));
        end
        if (it.last) begin
            hdr_count = 0;
            frame_hit = 1'b0;
        end
    endtask

    // Offers one transfer and holds it until the block takes it. A typed expectation,
    // where given, replaces the predicted bytes of that transfer.
    task automatic offer_item(input t_in_item it, input logic typed = 1'b0,
                              input t_out_beat typed_beat = '0);
        t_out_beat beats [$];
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= it.cmd;
        i_frame_byte  <= it.data;
        i_frame_last  <= it.last;
        i_entry_index <= it.idx;
        i_entry_ip    <= it.ip;
        i_entry_mac   <= it.mac;
        i_entry_valid <= it.ena;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_taken++;
        if (it.cmd == CMD_ENTRY) slot_writes++;
        forecast_frame_bytes(it, beats);
        if (typed) begin
            pending_beats.push_back(typed_beat);
        end else begin
            foreach (beats[b]) pending_beats.push_back(beats[b]);
        end
    endtask

    function automatic t_in_item make_entry(input logic [3:0] idx, input logic [31:0] ip,
                                            input logic [47:0] mac, input logic ena);
        t_in_item e;
        e.cmd  = CMD_ENTRY;
        e.data = 8'($urandom);     // ignored by an entry command, so left random
        e.last = 1'($urandom);
        e.idx  = idx;
        e.ip   = ip;
        e.mac  = mac;
        e.ena  = ena;
        return e;
    endfunction

    // Random slot write; half of them reuse an address already in the table so that
    // several slots often match the same destination.
    function automatic t_in_item random_entry();
        logic [63:0] r;
        logic [31:0] ip;
        r  = {$urandom, $urandom};
        ip = ($urandom_range(0, 1) == 0) ? slot_ip[$urandom_range(0, SLOTS - 1)] : $urandom;
        return make_entry(4'($urandom), ip, r[47:0], $urandom_range(0, 3) != 0);
    endfunction

    function automatic logic [7:0] frame_byte_at(input int k, input logic [15:0] etype,
                                                 input logic [7:0] proto,
                                                 input logic [31:0] dip);
        if (k == ETYPE_HI_AT) return etype[15:8];
        if (k == ETYPE_LO_AT) return etype[7:0];
        if (k == PROTO_BYTE) return proto;
        if (k >= DIP_BASE && k < DIP_BASE + 4) return dip[31 - 8 * (k - DIP_BASE) -: 8];
        return 8'($urandom);
    endfunction

    // Sends one frame byte by byte. An entry command can be woven in before byte
    // ins_at, and random slot writes can be sprinkled through the frame.
    task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                              input logic [31:0] dip, input int ins_at, input t_in_item ins,
                              input logic sprinkle);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            if (k == ins_at) offer_item(ins);
            if (sprinkle && $urandom_range(0, 99) < 4) offer_item(random_entry());
            it      = '0;
            it.cmd  = CMD_FRAME;
            it.data = frame_byte_at(k, etype, proto, dip);
            it.last = (k == len - 1);
            it.idx  = 4'($urandom);    // entry fields are don't-care on frame bytes
            it.ip   = $urandom;
            it.ena  = 1'($urandom);
            offer_item(it);
        end
    endtask

    // Mostly well-formed IPv4 TCP/UDP headers aimed at table addresses, with a share of
    // short frames, other EtherTypes and other protocols mixed in.
    task automatic run_random_frames(input int stop_at);
        int          pick;
        int          len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] dip;
        while (items_taken < stop_at) begin
            if ($urandom_range(0, 99) < 30) offer_item(random_entry());
            pick = $urandom_range(0, 99);
            len  = (pick < 20) ? $urandom_range(1, HDR_BYTES - 1) :
                   (pick < 30) ? HDR_BYTES : $urandom_range(HDR_BYTES + 1, HDR_BYTES + 12);
            pick = $urandom_range(0, 99);
            etype = (pick < 80) ? ETYPE_IPV4 :
                    (pick < 85) ? 16'h0806 :
                    (pick < 90) ? {ETYPE_IPV4_HI, 8'h01} :
                    (pick < 95) ? {ETYPE_IPV4_LO, ETYPE_IPV4_HI} : 16'($urandom);
            pick  = $urandom_range(0, 99);
            proto = (pick < 45) ? PROTO_TCP : (pick < 85) ? PROTO_UDP : 8'($urandom);
            dip   = ($urandom_range(0, 99) < 70) ? slot_ip[$urandom_range(0, SLOTS - 1)]
                                                 : $urandom;
            send_frame(len, etype, proto, dip, NO_INSERT, '0, 1'b1);
        end
    endtask

    function automatic t_stim_row row_byte(input logic [7:0] d, input logic l,
                                           input logic has_typed = 1'b0,
                                           input t_out_beat typed = '0);
        t_stim_row r;
        r           = '0;
        r.kind      = ROW_BYTE;
        r.item.cmd  = CMD_FRAME;
        r.item.data = d;
        r.item.last = l;
        r.has_typed = has_typed;
        r.typed     = typed;
        return r;
    endfunction

    function automatic t_stim_row row_entry(input logic [3:0] idx, input logic [31:0] ip,
                                            input logic [47:0] mac, input logic ena);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_ENTRY;
        r.item = make_entry(idx, ip, mac, ena);
        return r;
    endfunction

    function automatic t_stim_row row_frame(input int len, input logic [15:0] etype,
                                            input logic [7:0] proto, input logic [31:0] dip,
                                            input int ins_at = NO_INSERT,
                                            input t_in_item ins = '0);
        t_stim_row r;
        r        = '0;
        r.kind   = ROW_FRAME;
        r.len    = 7'(len);
        r.etype  = etype;
        r.proto  = proto;
        r.dip    = dip;
        r.ins_at = 7'(ins_at);
        r.item   = ins;
        return r;
    endfunction

    // Receiver: random stall at the phase's rate, forced high during the long hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= rx_hold || ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // The long hold-off counts its own cycles so the sender keeps offering bytes all
    // the while, filling the block until it stalls its input.
    initial begin : rx_pressure
        @(hold_kick);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Every accepted output byte is checked field by field against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch("unexpected out_byte", 64'(o_out_byte), 64'(0));
            end else begin
                head_beat = pending_beats.pop_front();
                if (o_out_byte !== head_beat.data) begin
                    flag_mismatch("out_byte", 64'(o_out_byte), 64'(head_beat.data));
                end
                if (o_out_last !== head_beat.last) begin
                    flag_mismatch("out_last", 64'(o_out_last), 64'(head_beat.last));
                end
                if (o_mac_rewritten !== head_beat.rw) begin
                    flag_mismatch("mac_rewritten", 64'(o_mac_rewritten), 64'(head_beat.rw));
                end
            end
            bytes_out++;
            if (o_out_last) begin
                frames_out++;
                if (o_mac_rewritten) frames_rewritten++;
            end
        end
    end

    initial begin : stimulus
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. One-byte frames are short frames whose output is obvious, so
        // their result is typed in; everything else goes through the predictor.
        directed_rows.push_back(row_byte(8'h00, 1'b1, 1'b1, make_beat(8'h00, 1'b1, 1'b0)));
        directed_rows.push_back(row_byte(8'hFF, 1'b1, 1'b1, make_beat(8'hFF, 1'b1, 1'b0)));
        directed_rows.push_back(row_entry(4'd0, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 1'b1));
        directed_rows.push_back(row_entry(4'd15, 32'hFFFF_FFFF, 48'h0, 1'b1));
        // Exactly one header long, TCP, hit on slot 0.
        directed_rows.push_back(row_frame(HDR_BYTES, ETYPE_IPV4, PROTO_TCP, 32'h0A00_0001));
        // UDP hit on the top slot, with a payload byte after the header.
        directed_rows.push_back(row_frame(HDR_BYTES + 1, ETYPE_IPV4, PROTO_UDP,
                                          32'hFFFF_FFFF));
        // A second slot with the same address: the higher one must win.
        directed_rows.push_back(row_entry(4'd7, 32'h0A00_0001, 48'h0123_4567_89AB, 1'b1));
        directed_rows.push_back(row_frame(HDR_BYTES + 2, ETYPE_IPV4, PROTO_TCP,
                                          32'h0A00_0001));
        // Disabling it hands the match back to slot 0.
        directed_rows.push_back(row_entry(4'd7, 32'h0A00_0001, 48'h0123_4567_89AB, 1'b0));
        directed_rows.push_back(row_frame(HDR_BYTES, ETYPE_IPV4, PROTO_UDP, 32'h0A00_0001));
        // Frames that do not qualify or do not match pass unchanged.
        directed_rows.push_back(row_frame(HDR_BYTES, 16'h0806, PROTO_TCP, 32'h0A00_0001));
        directed_rows.push_back(row_frame(HDR_BYTES, {ETYPE_IPV4_HI, 8'h01}, PROTO_TCP,
                                          32'h0A00_0001));
        directed_rows.push_back(row_frame(HDR_BYTES, ETYPE_IPV4, 8'h01, 32'h0A00_0001));
        directed_rows.push_back(row_frame(HDR_BYTES, ETYPE_IPV4, PROTO_TCP, 32'h0A00_00FF));
        // Longest short frame: ends one byte before the header is complete.
        directed_rows.push_back(row_frame(HDR_BYTES - 1, ETYPE_IPV4, PROTO_TCP,
                                          32'h0A00_0001));
        // A slot written in the middle of a header counts for that frame's lookup.
        directed_rows.push_back(row_frame(HDR_BYTES + 2, ETYPE_IPV4, PROTO_TCP,
                                          32'hC0A8_0001, 10,
                                          make_entry(4'd3, 32'hC0A8_0001,
                                                     48'h0200_0000_0003, 1'b1)));
        // Removing it after the header does not undo the decision for this frame.
        directed_rows.push_back(row_frame(HDR_BYTES + 2, ETYPE_IPV4, PROTO_UDP,
                                          32'hC0A8_0001, HDR_BYTES + 1,
                                          make_entry(4'd3, 32'hC0A8_0001,
                                                     48'h0200_0000_0003, 1'b0)));
        directed_rows.push_back(row_byte(8'h5A, 1'b0));
        directed_rows.push_back(row_byte(8'hA5, 1'b1));

        foreach (directed_rows[n]) begin
            case (directed_rows[n].kind)
                ROW_BYTE: begin
                    offer_item(directed_rows[n].item, directed_rows[n].has_typed,
                               directed_rows[n].typed);
                end
                ROW_ENTRY: begin
                    offer_item(directed_rows[n].item);
                end
                default: begin
                    send_frame(int'(directed_rows[n].len), directed_rows[n].etype,
                               directed_rows[n].proto, directed_rows[n].dip,
                               int'(directed_rows[n].ins_at), directed_rows[n].item, 1'b0);
                end
            endcase
        end

        // Random part in three idling phases: receiver sparse, then sender sparse, then
        // both at full rate with one long receiver hold-off at its start.
        run_random_frames(items_taken + ITEMS_PHASE);
        snd_idle_pct = 70;
        rcv_idle_pct <= 23;
        run_random_frames(items_taken + ITEMS_PHASE);
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        -> hold_kick;
        run_random_frames(items_taken + ITEMS_PHASE);
        i_in_valid <= 1'b0;

        // Drain: wait for every owed byte, then a little longer to catch strays.
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Covered %0d input transfers (%0d slot writes), %0d bytes in %0d frames,",
                 items_taken, slot_writes, bytes_out, frames_out);
        $display("of which %0d had the destination MAC replaced; long hold-off of %0d cycles.",
                 frames_rewritten, HOLD_CYCLES);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d output bytes still owed.", pending_beats.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/dmr_pkg.sv
design/dmr_ctrl.sv
design/dmr_dp.sv
design/ipv4_dest_mac_rewriter_top.sv
dv/ipv4_dest_mac_rewriter_top_tb.sv
